>>> hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared constants, codes and beat payload types of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  // Step table geometry; the step index field is four bits wide.
  localparam int unsigned MaxSteps   = 16;
  localparam int unsigned StepW      = $clog2(MaxSteps);
  localparam int unsigned StepCountW = 5;
  localparam int unsigned DutyW      = 16;
  localparam int unsigned RawDelayW  = 16;
  localparam int unsigned RepeatW    = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;

  // A repeat count of minus one plays forever.
  localparam logic [RepeatW-1:0] RepeatForever = '1;

  // Input beat operations.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } lps_op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP_COUNT = 1'b0,
    REG_OFF_DUTY   = 1'b1
  } lps_reg_e;

  // One input beat.
  typedef struct packed {
    lps_op_e                     opcode;
    logic [StepW-1:0]            step_index;
    logic [DutyW-1:0]            step_duty;
    logic [RawDelayW-1:0]        step_start_delay;
    logic [RawDelayW-1:0]        step_end_delay;
    logic signed [RepeatW-1:0]   repeat_count;
  } lps_in_t;

  // One result beat.
  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             playing;
    logic             done_res;
    logic             start_error;
  } lps_out_t;

endpackage

`default_nettype wire

>>> hdl/lps_step_table.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer step table
// Holds duty, start delay and end delay per step; delays are saturated to
// the counter width on write and read back combinationally at one address.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_step_table
  import lps_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [StepW-1:0]      wr_idx_i,
  input  wire logic [DutyW-1:0]      wr_duty_i,
  input  wire logic [RawDelayW-1:0]  wr_start_i,
  input  wire logic [RawDelayW-1:0]  wr_end_i,
  input  wire logic [StepW-1:0]      rd_idx_i,
  output logic      [DutyW-1:0]      rd_duty_o,
  output logic      [DELAY_BITS-1:0] rd_start_o,
  output logic      [DELAY_BITS-1:0] rd_end_o
);

  // Width that holds both a raw delay and the counter's largest value.
  localparam int unsigned ExtW = (DELAY_BITS > RawDelayW) ? DELAY_BITS : RawDelayW;
  localparam logic [ExtW-1:0] DelayMax = ExtW'((64'd1 << DELAY_BITS) - 64'd1);

  logic [DutyW-1:0]      duty_q  [MaxSteps];
  logic [DELAY_BITS-1:0] start_q [MaxSteps];
  logic [DELAY_BITS-1:0] end_q   [MaxSteps];

  logic [ExtW-1:0]       start_ext;
  logic [ExtW-1:0]       end_ext;
  logic [DELAY_BITS-1:0] start_sat;
  logic [DELAY_BITS-1:0] end_sat;

  // Saturate delays that do not fit the tick counter.
  always_comb begin
    start_ext = ExtW'(wr_start_i);
    end_ext   = ExtW'(wr_end_i);
    start_sat = (start_ext > DelayMax) ? DELAY_BITS'(DelayMax) : DELAY_BITS'(start_ext);
    end_sat   = (end_ext > DelayMax) ? DELAY_BITS'(DelayMax) : DELAY_BITS'(end_ext);
  end

  // Every four-bit index addresses an entry, so no range check is needed.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      duty_q[wr_idx_i]  <= wr_duty_i;
      start_q[wr_idx_i] <= start_sat;
      end_q[wr_idx_i]   <= end_sat;
    end
  end

  // Read port at the current step pointer.
  assign rd_duty_o  = duty_q[rd_idx_i];
  assign rd_start_o = start_q[rd_idx_i];
  assign rd_end_o   = end_q[rd_idx_i];

endmodule

`default_nettype wire

>>> hdl/lps_player.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer player
// Play state, configuration registers and the single-pass next-state logic
// that turns one beat into the updated state and its result.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_player
  import lps_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [CfgDataW-1:0]   cfg_data_i,
  input  wire logic                  fire_i,
  input  wire lps_in_t               item_i,
  output logic      [StepW-1:0]      rd_idx_o,
  input  wire logic [DutyW-1:0]      rd_duty_i,
  input  wire logic [DELAY_BITS-1:0] rd_start_i,
  input  wire logic [DELAY_BITS-1:0] rd_end_i,
  output lps_out_t                   res_o
);

  logic [StepW-1:0]      step_ptr_q, step_ptr_d;
  logic                  hold_q, hold_d;
  logic [DELAY_BITS-1:0] tick_q, tick_d;
  logic [RepeatW-1:0]    repeats_q, repeats_d;
  logic                  running_q, running_d;
  logic [DutyW-1:0]      duty_q, duty_d;
  logic [StepCountW-1:0] steps_cfg_q, steps_cfg_d;
  logic [DutyW-1:0]      off_duty_q, off_duty_d;

  logic                  done;
  logic                  err;
  logic [StepCountW-1:0] steps_used;
  logic [DELAY_BITS:0]   tick_next;
  logic [DELAY_BITS-1:0] limit;
  logic [StepCountW-1:0] ptr_next;

  assign rd_idx_o = step_ptr_q;

  // Steps in use: zero acts as one, large counts clip to the table size.
  always_comb begin
    if (steps_cfg_q == '0) begin
      steps_used = StepCountW'(1);
    end else if (steps_cfg_q > StepCountW'(MaxSteps)) begin
      steps_used = StepCountW'(MaxSteps);
    end else begin
      steps_used = steps_cfg_q;
    end
  end

  assign limit     = hold_q ? rd_end_i : rd_start_i;
  assign tick_next = {1'b0, tick_q} + (DELAY_BITS+1)'(1);
  assign ptr_next  = StepCountW'(step_ptr_q) + StepCountW'(1);

  // Next state for one configuration write or one beat.
  always_comb begin
    step_ptr_d   = step_ptr_q;
    hold_d       = hold_q;
    tick_d       = tick_q;
    repeats_d    = repeats_q;
    running_d    = running_q;
    duty_d       = duty_q;
    steps_cfg_d  = steps_cfg_q;
    off_duty_d   = off_duty_q;
    done         = 1'b0;
    err          = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STEP_COUNT: begin
          steps_cfg_d = cfg_data_i[StepCountW-1:0];
        end
        REG_OFF_DUTY: begin
          off_duty_d = cfg_data_i[DutyW-1:0];
          if (!running_q) begin
            duty_d = cfg_data_i[DutyW-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    if (fire_i) begin
      case (item_i.opcode)
        OP_TICK: begin
          if (running_q) begin
            if (tick_next < {1'b0, limit}) begin
              tick_d = tick_next[DELAY_BITS-1:0];
            end else if (!hold_q) begin
              // Start delay over: drive the step's duty.
              tick_d = '0;
              duty_d = rd_duty_i;
              hold_d = 1'b1;
            end else begin
              tick_d = '0;
              hold_d = 1'b0;
              if (ptr_next < steps_used) begin
                step_ptr_d = ptr_next[StepW-1:0];
              end else if (repeats_q == RepeatForever) begin
                step_ptr_d = '0;
              end else if (repeats_q != '0 && !repeats_q[RepeatW-1]) begin
                repeats_d  = repeats_q - RepeatW'(1);
                step_ptr_d = '0;
              end else begin
                // Last pass finished.
                step_ptr_d = '0;
                running_d  = 1'b0;
                duty_d     = off_duty_q;
                done       = 1'b1;
              end
            end
          end
        end
        OP_WRITE: begin
          // The table takes the write; play state is untouched.
        end
        OP_START: begin
          if (running_q) begin
            err = 1'b1;
          end else begin
            running_d  = 1'b1;
            step_ptr_d = '0;
            hold_d     = 1'b0;
            tick_d     = '0;
            repeats_d  = item_i.repeat_count;
          end
        end
        OP_STOP: begin
          if (running_q) begin
            running_d  = 1'b0;
            step_ptr_d = '0;
            hold_d     = 1'b0;
            tick_d     = '0;
            duty_d     = off_duty_q;
            done       = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Play state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ptr_q   <= '0;
      hold_q       <= 1'b0;
      tick_q       <= '0;
      repeats_q    <= '0;
      running_q    <= 1'b0;
      duty_q       <= '0;
      steps_cfg_q  <= StepCountW'(1);
      off_duty_q   <= '0;
    end else begin
      step_ptr_q   <= step_ptr_d;
      hold_q       <= hold_d;
      tick_q       <= tick_d;
      repeats_q    <= repeats_d;
      running_q    <= running_d;
      duty_q       <= duty_d;
      steps_cfg_q  <= steps_cfg_d;
      off_duty_q   <= off_duty_d;
    end
  end

  // Result of the beat, taken from the updated state.
  always_comb begin
    res_o.duty        = duty_d;
    res_o.playing     = running_d;
    res_o.done_res    = done;
    res_o.start_error = err;
  end

`ifndef SYNTHESIS
  // When idle, the play position is parked at the first step's start delay.
  a_idle_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (step_ptr_q == '0 && !hold_q && tick_q == '0))
    else $error("idle sequencer has a stale play position");

  // A rejected start can only come from a running sequencer.
  a_err_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && err) |-> running_q)
    else $error("start rejected while idle");

  // Finishing or stopping leaves the sequencer idle at the off duty.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && done) |=> (!running_q && duty_q == off_duty_q))
    else $error("sequencer still running after done");

  // The step pointer never reaches past the steps in use.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (StepCountW'(step_ptr_q) < steps_used))
    else $error("step pointer out of table");
`endif

endmodule

`default_nettype wire

>>> hdl/led_pattern_sequencer.sv
// Flow: a beat held in the input register is processed in one pass and its
// result is written to the result register once that register can take it.
// Throughput: one beat per cycle unless the result side stalls; the single-pass
// state update and step table read finish in the cycle the input register drains.
// Reset: asynchronous, active low; play stops, duty reads zero, the step
// count register resets to one; the step table is undefined until written.
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Top level: input register, step table, player and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_sequencer
  import lps_pkg::*;
#(
  parameter int unsigned DELAY_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lps_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lps_out_t                 out_data_o
);

  logic     in_valid_q;
  lps_in_t  in_q;
  logic     out_valid_q;
  lps_out_t out_q;
  logic     fire;
  lps_out_t res;

  logic [StepW-1:0]      rd_idx;
  logic [DutyW-1:0]      rd_duty;
  logic [DELAY_BITS-1:0] rd_start;
  logic [DELAY_BITS-1:0] rd_end;

  // A held beat is processed once the result register can take its result.
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  lps_step_table #(
    .DELAY_BITS (DELAY_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .we_i       (fire && in_q.opcode == OP_WRITE),
    .wr_idx_i   (in_q.step_index),
    .wr_duty_i  (in_q.step_duty),
    .wr_start_i (in_q.step_start_delay),
    .wr_end_i   (in_q.step_end_delay),
    .rd_idx_i   (rd_idx),
    .rd_duty_o  (rd_duty),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end)
  );

  lps_player #(
    .DELAY_BITS (DELAY_BITS)
  ) u_player (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (in_q),
    .rd_idx_o    (rd_idx),
    .rd_duty_i   (rd_duty),
    .rd_start_i  (rd_start),
    .rd_end_i    (rd_end),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// LED pattern sequencer testbench
// Drives command and tick beats into the sequencer and checks every result
// beat against a cycle-free predictor of the step player. A short scripted
// run covers the corner cases, then random play sequences run under several
// register settings and flow-control mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_led_pattern_sequencer;
  import lps_pkg::*;

  localparam int PhaseBeats     = 110;
  localparam int ScriptLen      = 25;
  localparam int HoldOffCycles  = 60;
  localparam int SettleCycles   = 6;
  localparam int WatchdogLimit  = 2000;
  localparam int StepPlan [8]   = '{0, 31, 16, 2, 1, 4, 17, 3};

  // One row of the scripted run; pinned rows carry a hand-written result.
  typedef struct {
    lps_in_t  beat;
    bit       pinned;
    lps_out_t result;
  } script_row_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index   = '0;
  logic [CfgDataW-1:0] cfg_data    = '0;
  logic                in_valid    = 1'b0;
  lps_in_t             in_data     = '0;
  logic                out_ready   = 1'b0;
  logic                in_ready;
  logic                out_valid;
  lps_out_t            out_data;

  // Flow-control knobs shared by the sender and the receiver.
  int sender_pct   = 0;
  int stall_pct    = 0;
  bit hold_request = 1'b0;

  int          fail_count    = 0;
  int          counted_beats = 0;
  lps_out_t    awaited_results [$];
  script_row_t script [ScriptLen];

  // Predicted sequencer state.
  logic [DutyW-1:0]     duty_tbl [MaxSteps];
  logic [RawDelayW-1:0] lead_tbl [MaxSteps];
  logic [RawDelayW-1:0] tail_tbl [MaxSteps];
  bit                   entry_written [MaxSteps];
  int                   cur_step       = 0;
  int                   tick_cnt       = 0;
  bit                   in_hold        = 1'b0;
  bit                   seq_active     = 1'b0;
  logic [RepeatW-1:0]   passes_left    = '0;
  logic [DutyW-1:0]     duty_now       = '0;
  logic [DutyW-1:0]     off_duty_reg   = '0;
  logic [4:0]           seq_len_reg    = 5'd1;

  led_pattern_sequencer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // Number of table steps a pass walks through.
  function automatic int effective_steps();
    int n;
    n = seq_len_reg;
    if (n == 0) n = 1;
    if (n > MaxSteps) n = MaxSteps;
    return n;
  endfunction

  // A start is only legal once every step in use has been written.
  function automatic bit tables_ready();
    for (int i = 0; i < effective_steps(); i++) begin
      if (!entry_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // One tick of play; returns 1 when the animation finishes on it.
  function automatic bit advance_step_timer();
    int limit;
    int nxt;
    limit = in_hold ? int'(tail_tbl[cur_step]) : int'(lead_tbl[cur_step]);
    nxt   = tick_cnt + 1;
    if (nxt < limit) begin
      tick_cnt = nxt;
      return 1'b0;
    end
    tick_cnt = 0;
    if (!in_hold) begin
      duty_now = duty_tbl[cur_step];
      in_hold  = 1'b1;
      return 1'b0;
    end
    in_hold = 1'b0;
    if (cur_step + 1 < effective_steps()) begin
      cur_step++;
      return 1'b0;
    end
    cur_step = 0;
    if (passes_left == RepeatForever) return 1'b0;
    if (passes_left >= 8'h01 && passes_left <= 8'h7F) begin
      passes_left--;
      return 1'b0;
    end
    seq_active = 1'b0;
    duty_now   = off_duty_reg;
    return 1'b1;
  endfunction

  // Applies one accepted beat to the predicted state and returns its result.
  function automatic lps_out_t play_beat(lps_in_t beat);
    lps_out_t res;
    bit       ended;
    bit       rejected;
    ended    = 1'b0;
    rejected = 1'b0;
    case (beat.opcode)
      OP_TICK: begin
        if (seq_active) ended = advance_step_timer();
      end
      OP_WRITE: begin
        duty_tbl[beat.step_index]      = beat.step_duty;
        lead_tbl[beat.step_index]      = beat.step_start_delay;
        tail_tbl[beat.step_index]      = beat.step_end_delay;
        entry_written[beat.step_index] = 1'b1;
      end
      OP_START: begin
        if (seq_active) begin
          rejected = 1'b1;
        end else begin
          seq_active  = 1'b1;
          cur_step    = 0;
          in_hold     = 1'b0;
          tick_cnt    = 0;
          passes_left = beat.repeat_count;
        end
      end
      default: begin
        if (seq_active) begin
          seq_active = 1'b0;
          cur_step   = 0;
          in_hold    = 1'b0;
          tick_cnt   = 0;
          duty_now   = off_duty_reg;
          ended      = 1'b1;
        end
      end
    endcase
    res.duty        = duty_now;
    res.playing     = seq_active;
    res.done_res    = ended;
    res.start_error = rejected;
    return res;
  endfunction

  function automatic script_row_t script_row(lps_op_e op, logic [StepW-1:0] idx,
                                            logic [DutyW-1:0] duty,
                                            logic [RawDelayW-1:0] lead,
                                            logic [RawDelayW-1:0] tail,
                                            logic [RepeatW-1:0] rep,
                                            bit pinned = 1'b0,
                                            logic [DutyW-1:0] o_duty = '0,
                                            bit o_play = 1'b0, bit o_done = 1'b0,
                                            bit o_err = 1'b0);
    script_row_t r;
    r.beat.opcode           = op;
    r.beat.step_index       = idx;
    r.beat.step_duty        = duty;
    r.beat.step_start_delay = lead;
    r.beat.step_end_delay   = tail;
    r.beat.repeat_count     = rep;
    r.pinned                = pinned;
    r.result.duty           = o_duty;
    r.result.playing        = o_play;
    r.result.done_res       = o_done;
    r.result.start_error    = o_err;
    return r;
  endfunction

  // Every field random; callers override the ones that matter.
  function automatic lps_in_t random_beat();
    lps_in_t b;
    b.opcode           = lps_op_e'($urandom_range(3, 0));
    b.step_index       = StepW'($urandom_range(MaxSteps - 1, 0));
    b.step_duty        = DutyW'($urandom_range(65535, 0));
    b.step_start_delay = RawDelayW'($urandom_range(65535, 0));
    b.step_end_delay   = RawDelayW'($urandom_range(65535, 0));
    b.repeat_count     = RepeatW'($urandom_range(255, 0));
    return b;
  endfunction

  // Mostly short delays so passes complete; now and then a full-range one.
  function automatic logic [RawDelayW-1:0] pick_delay();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 60) return RawDelayW'($urandom_range(1, 0));
    if (roll < 85) return RawDelayW'($urandom_range(4, 2));
    if (roll < 95) return RawDelayW'($urandom_range(30, 5));
    return RawDelayW'($urandom_range(65535, 0));
  endfunction

  function automatic lps_in_t write_beat(logic [StepW-1:0] idx);
    lps_in_t b;
    b                  = random_beat();
    b.opcode           = OP_WRITE;
    b.step_index       = idx;
    b.step_start_delay = pick_delay();
    b.step_end_delay   = pick_delay();
    return b;
  endfunction

  function automatic lps_in_t start_beat();
    lps_in_t b;
    int      roll;
    b        = random_beat();
    b.opcode = OP_START;
    roll     = $urandom_range(99, 0);
    if (roll < 40)      b.repeat_count = 8'sd0;
    else if (roll < 65) b.repeat_count = RepeatW'($urandom_range(2, 1));
    else if (roll < 77) b.repeat_count = RepeatForever;
    else if (roll < 85) b.repeat_count = RepeatW'($urandom_range(254, 128));
    else if (roll < 90) b.repeat_count = 8'sd127;
    return b;
  endfunction

  function automatic lps_in_t op_beat(lps_op_e op);
    lps_in_t b;
    b        = random_beat();
    b.opcode = op;
    return b;
  endfunction

  // Offers one beat, waits for its handshake and records its expected result.
  task automatic send_beat(lps_in_t beat, bit pinned = 1'b0, lps_out_t fixed = '0);
    lps_out_t predicted;
    @(negedge clk);
    if ($urandom_range(99, 0) < sender_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    if (beat.opcode == OP_WRITE || beat.opcode == OP_START || seq_active) begin
      counted_beats++;
    end
    predicted = play_beat(beat);
    awaited_results.push_back(pinned ? fixed : predicted);
  endtask

  // Drops valid and waits until every result has come back.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(lps_reg_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_STEP_COUNT) begin
      seq_len_reg = data[4:0];
    end else begin
      off_duty_reg = data;
      if (!seq_active) duty_now = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One play sequence: table writes, a start, ticks with some noise mixed in.
  task automatic play_sequence();
    lps_in_t noise;
    int      budget;
    if ($urandom_range(99, 0) < 10) begin
      noise = random_beat();
      if (noise.opcode == OP_WRITE) noise = write_beat(noise.step_index);
      if (noise.opcode == OP_START && !seq_active && !tables_ready()) noise.opcode = OP_TICK;
      send_beat(noise);
      return;
    end
    repeat ($urandom_range(3, 0)) send_beat(write_beat(StepW'($urandom_range(MaxSteps - 1, 0))));
    for (int i = 0; i < effective_steps(); i++) begin
      if (!entry_written[i]) send_beat(write_beat(StepW'(i)));
    end
    send_beat(start_beat());
    budget = ($urandom_range(99, 0) < 20) ? $urandom_range(6, 0) : $urandom_range(80, 10);
    while (seq_active && budget > 0) begin
      if ($urandom_range(99, 0) < 6) begin
        noise = random_beat();
        if (noise.opcode == OP_WRITE) noise = write_beat(noise.step_index);
        send_beat(noise);
      end else begin
        send_beat(op_beat(OP_TICK));
      end
      budget--;
    end
    if (seq_active && $urandom_range(99, 0) < 80) send_beat(op_beat(OP_STOP));
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready    <= 1'b0;
        hold_request = 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end
      out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // Result checker: each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    lps_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with no expectation: %h", out_data);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.duty !== want.duty) begin
          $error("duty mismatch: expected %h, got %h", want.duty, out_data.duty);
          fail_count++;
        end
        if (out_data.playing !== want.playing) begin
          $error("playing mismatch: expected %b, got %b", want.playing, out_data.playing);
          fail_count++;
        end
        if (out_data.done_res !== want.done_res) begin
          $error("done_res mismatch: expected %b, got %b", want.done_res, out_data.done_res);
          fail_count++;
        end
        if (out_data.start_error !== want.start_error) begin
          $error("start_error mismatch: expected %b, got %b",
                 want.start_error, out_data.start_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Main sequence: reset, scripted corner cases, then random phases.
  initial begin
    logic [DutyW-1:0] off_value;

    // Scripted run at reset settings: one step in use, off duty zero.
    script[0]  = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1);
    script[1]  = script_row(OP_STOP,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1);
    script[2]  = script_row(OP_WRITE, 4'd0,  16'hFFFF, 16'h0000, 16'h0000, 8'h00, 1'b1);
    script[3]  = script_row(OP_WRITE, 4'd15, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
    script[4]  = script_row(OP_START, 4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                            16'h0000, 1'b1);
    // A start while playing is rejected.
    script[5]  = script_row(OP_START, 4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h7F, 1'b1,
                            16'h0000, 1'b1, 1'b0, 1'b1);
    // Zero delays: the first tick drives the step's duty, the second ends the pass.
    script[6]  = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                            16'hFFFF, 1'b1);
    script[7]  = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                            16'h0000, 1'b0, 1'b1);
    // Endless repeat, then aborted by a stop.
    script[8]  = script_row(OP_WRITE, 4'd0,  16'h1234, 16'h0001, 16'h0002, 8'h00);
    script[9]  = script_row(OP_START, 4'd0,  16'h0000, 16'h0000, 16'h0000, 8'hFF);
    script[10] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[11] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[12] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[13] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[14] = script_row(OP_STOP,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                            16'h0000, 1'b0, 1'b1);
    // A negative repeat other than forever plays a single pass.
    script[15] = script_row(OP_START, 4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h80);
    script[16] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[17] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[18] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                            16'h0000, 1'b0, 1'b1);
    // One extra pass, with the step rewritten while playing.
    script[19] = script_row(OP_START, 4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h01);
    script[20] = script_row(OP_WRITE, 4'd0,  16'h0001, 16'h0000, 16'h0000, 8'h00);
    script[21] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[22] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[23] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00);
    script[24] = script_row(OP_TICK,  4'd0,  16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
                            16'h0000, 1'b0, 1'b1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < ScriptLen; i++) begin
      send_beat(script[i].beat, script[i].pinned, script[i].result);
    end

    // Random phases, each with its own register setting and flow-control mix.
    for (int k = 0; k < 8; k++) begin
      if (seq_active) send_beat(op_beat(OP_STOP));
      quiesce();
      if (k == 0)      off_value = 16'hFFFF;
      else if (k == 1) off_value = 16'h0000;
      else if (k == 4) off_value = 16'h8000;
      else             off_value = DutyW'($urandom_range(65535, 0));
      write_register(REG_STEP_COUNT, {11'($urandom_range(2047, 0)), 5'(StepPlan[k])});
      write_register(REG_OFF_DUTY, off_value);
      case (k % 4)
        0: begin
          sender_pct = 0;
          stall_pct  = 0;
        end
        1: begin
          sender_pct = 54;
          stall_pct  = 0;
        end
        2: begin
          sender_pct = 0;
          stall_pct  = 54;
        end
        default: begin
          sender_pct = 9;
          stall_pct  = 9;
        end
      endcase
      if (k == 0) hold_request = 1'b1;
      counted_beats = 0;
      while (counted_beats < PhaseBeats) play_sequence();
    end

    if (seq_active) send_beat(op_beat(OP_STOP));
    quiesce();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
